// ===== design/upd_pkg.sv =====
// upd_pkg: shared types, constants and hex-pair decode for the URL percent decoder.
// No dependencies.
`default_nettype none
package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [15:0] LIMIT_RESET = 16'd1024;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } upd_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        is_final;
        logic        status;
        logic [15:0] out_count;
    } upd_out_t;

    // {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == SPACE_CHAR) || (c inside {[8'h09:8'h0D]});
    endfunction

    // base-16 parse of the two-char string c1 c2, low 8 bits
    function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
        logic [4:0] d1;
        logic [4:0] d2;
        logic [7:0] r;
        d1 = hex_digit(c1);
        d2 = hex_digit(c2);
        r  = 8'd0;
        if (c1 == 8'd0) begin
            r = 8'd0;
        end else if (is_white(c1) || c1 == PLUS_CHAR) begin
            r = d2[4] ? {4'd0, d2[3:0]} : 8'd0;
        end else if (c1 == MINUS_CHAR) begin
            r = d2[4] ? 8'(8'd0 - {4'd0, d2[3:0]}) : 8'd0;
        end else if (d1[4]) begin
            r = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/url_percent_decoder.sv =====
// url_percent_decoder: streaming URL percent-decoder, top level.
// Depends on upd_pkg and upd_core.
//
// channel  signals                        beat
// input    in_valid  in_stall  in_data     one raw byte + last flag
// output   out_valid out_stall out_data    zero or one result per input beat
// config   cfg_valid cfg_ready cfg_data    out_limit write (always ready)
//
// One beat per cycle sustained while out_stall is low; input register, then result register.
// A beat that yields no result leaves the pipe after its decode cycle.
// out_stall backs up through the result register into in_stall in the same cycle.
// Reset clears the escape state, the count, and sets out_limit to 1024.
`default_nettype none
module url_percent_decoder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire upd_pkg::upd_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output upd_pkg::upd_out_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data
);
    import upd_pkg::*;

    logic        s1_valid_reg;
    upd_in_t     s1_data_reg;
    logic        out_valid_reg;
    upd_out_t    out_data_reg;
    logic [15:0] limit_reg;

    logic        s1_adv;
    logic        fire;
    logic        in_acc;
    logic        produce;
    upd_out_t    result;

    assign s1_adv    = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    upd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (s1_data_reg),
        .limit   (limit_reg),
        .produce (produce),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end else begin
            if (in_acc) s1_valid_reg <= 1'b1;
            else if (fire) s1_valid_reg <= 1'b0;
            if (fire) out_valid_reg <= produce;
            else if (!out_stall) out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) s1_data_reg <= in_data;
        if (fire) out_data_reg <= result;
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");
    a_nonfinal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_final |-> out_data.status == 1'b0
        && out_data.out_count == 16'd0)
        else $error("status or count on a non-final result");
    a_nobyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0 && out_data.is_final)
        else $error("empty result that is not final");

endmodule
`default_nettype wire

// ===== design/upd_core.sv =====
// upd_core: escape tracking state and per-byte decode step.
// Depends on upd_pkg.
`default_nettype none
module upd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire upd_pkg::upd_in_t item,
    input  wire logic [15:0]     limit,
    output logic                 produce,
    output upd_pkg::upd_out_t    result
);
    import upd_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  fc_reg, fc_next;
    logic [15:0] count_reg, count_next;

    logic        emit;
    logic [7:0]  value;
    logic        err;
    logic [15:0] count_inc;

    always_comb
    begin
        emit       = 1'b0;
        value      = 8'd0;
        err        = 1'b0;
        phase_next = phase_reg;
        fc_next    = fc_reg;
        case (phase_reg)
            PH_FIRST:
            begin
                fc_next = item.in_byte;
                if (item.is_last) err = 1'b1;
                else phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                value      = decode_pair(fc_reg, item.in_byte);
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                if (count_reg < limit) begin
                    if (item.in_byte == PCT_CHAR) begin
                        if (item.is_last) err = 1'b1;
                        else phase_next = PH_FIRST;
                    end else begin
                        value = item.in_byte;
                        emit  = 1'b1;
                    end
                end
            end
        endcase
        count_inc  = count_reg + {15'd0, emit};
        count_next = count_inc;
        if (item.is_last) begin
            phase_next = PH_IDLE;
            fc_next    = 8'd0;
            count_next = 16'd0;
        end
        produce           = emit || item.is_last;
        result.out_byte   = emit ? value : 8'd0;
        result.byte_valid = emit;
        result.is_final   = item.is_last;
        result.status     = item.is_last ? err : 1'b0;
        result.out_count  = item.is_last ? count_inc : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            fc_reg    <= 8'd0;
            count_reg <= 16'd0;
        end else if (fire) begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            count_reg <= count_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.is_last |=> phase_reg == PH_IDLE && count_reg == 16'd0 && fc_reg == 8'd0)
        else $error("state not cleared after last beat");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(count_reg) && $stable(fc_reg))
        else $error("state moved without a beat");
    a_second_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_SECOND |-> produce && result.byte_valid)
        else $error("escape completion gave no byte");

endmodule
`default_nettype wire

// ===== test/upd_decode_checker.sv =====
// upd_decode_checker: watches the URL percent decoder's channels, predicts each
// decoded result and compares it with what the block delivers. Depends on upd_pkg.
`timescale 1ns / 1ps
module upd_decode_checker
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  upd_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  upd_out_t out_data,
    input  logic     cfg_valid,
    input  logic     cfg_ready,
    input  logic [15:0] cfg_data,
    output int       mismatch_count,
    output int       results_owed
);

    logic [15:0] limit_q;
    logic [1:0]  esc_phase;
    logic [7:0]  esc_first;
    logic [15:0] emitted;
    upd_out_t    decoded_q[$];

    logic        produced;
    logic [7:0]  byte_val;
    logic        trunc;
    upd_out_t    owed;

    initial
    begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    function automatic int hex_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    // strtol base 16 on a two-char string, low 8 bits
    function automatic logic [7:0] escape_value(input logic [7:0] c1, input logic [7:0] c2);
        int h1;
        int h2;
        logic white;
        h1 = hex_of(c1);
        h2 = hex_of(c2);
        white = (c1 == SPACE_CHAR) || (c1 >= 8'h09 && c1 <= 8'h0D);
        if (c1 == 8'h00) return 8'h00;
        if (white || c1 == PLUS_CHAR) return (h2 < 0) ? 8'h00 : 8'(h2);
        if (c1 == MINUS_CHAR) return (h2 < 0) ? 8'h00 : 8'(-h2);
        if (h1 < 0) return 8'h00;
        if (h2 < 0) return 8'(h1);
        return 8'(h1 * 16 + h2);
    endfunction

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, seen);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_q   = LIMIT_RESET;
            esc_phase = PH_IDLE;
            esc_first = 8'h00;
            emitted   = 16'd0;
            decoded_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result beat with nothing owed: 0x%0h", out_data);
                    mismatch_count++;
                end
                else
                begin
                    owed = decoded_q.pop_front();
                    check_field("out_byte", owed.out_byte, out_data.out_byte);
                    check_field("byte_valid", owed.byte_valid, out_data.byte_valid);
                    check_field("is_final", owed.is_final, out_data.is_final);
                    check_field("status", owed.status, out_data.status);
                    check_field("out_count", owed.out_count, out_data.out_count);
                end
            end

            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;

            if (in_valid && !in_stall)
            begin
                produced = 1'b0;
                byte_val = 8'h00;
                trunc    = 1'b0;
                case (esc_phase)
                    PH_FIRST:
                    begin
                        esc_first = in_data.in_byte;
                        if (in_data.is_last) trunc = 1'b1;
                        else esc_phase = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        byte_val  = escape_value(esc_first, in_data.in_byte);
                        produced  = 1'b1;
                        esc_phase = PH_IDLE;
                    end
                    default:
                    begin
                        if (emitted < limit_q)
                        begin
                            if (in_data.in_byte == PCT_CHAR)
                            begin
                                if (in_data.is_last) trunc = 1'b1;
                                else esc_phase = PH_FIRST;
                            end
                            else
                            begin
                                byte_val = in_data.in_byte;
                                produced = 1'b1;
                            end
                        end
                    end
                endcase
                if (produced) emitted = emitted + 16'd1;
                if (produced || in_data.is_last)
                begin
                    owed.out_byte   = produced ? byte_val : 8'h00;
                    owed.byte_valid = produced;
                    owed.is_final   = in_data.is_last;
                    owed.status     = in_data.is_last ? trunc : 1'b0;
                    owed.out_count  = in_data.is_last ? emitted : 16'd0;
                    decoded_q.push_back(owed);
                end
                if (in_data.is_last)
                begin
                    esc_phase = PH_IDLE;
                    esc_first = 8'h00;
                    emitted   = 16'd0;
                end
            end
        end
        results_owed = decoded_q.size();
    end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for url_percent_decoder; byte strings, limit writes
// and stall patterns. Depends on upd_pkg, url_percent_decoder and upd_decode_checker.
`timescale 1ns / 1ps
module tb;
    import upd_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 105;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    upd_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    upd_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int mismatch_count;
    int results_owed;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    int quiet = 0;
    int items_sent = 0;

    logic [7:0] text_q[$];
    string hex_chars = "0123456789abcdefABCDEF";
    int limit_list[8] = '{1, 3, 16, 65535, 0, 7, 1024, 2};

    url_percent_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    upd_decode_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[url_percent_decoder] ERROR");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.in_byte <= b;
        in_data.is_last <= last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // wait for every owed result, then let a beat with no result leave the pipe
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5: return hex_chars[$urandom_range(0, 21)];
            6: return 8'h00;
            7: return ($urandom_range(0, 5) == 0) ? SPACE_CHAR : 8'($urandom_range(9, 13));
            8: return PLUS_CHAR;
            9: return MINUS_CHAR;
            10: return "x";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_random_text();
        int len;
        int pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        while (text_q.size() < len)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                text_q.push_back(PCT_CHAR);
                text_q.push_back(escape_char());
                text_q.push_back(escape_char());
            end
            else if (pick < 5)
                text_q.push_back(escape_char());
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        // cut an escape short now and then
        if (text_q.size() > 2 && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
            if ($urandom_range(0, 1) == 0) text_q.push_back(PCT_CHAR);
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: byte extremes, escape corner cases, truncation
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        push_str("%41%");
        send_text();
        push_str("%4");
        send_text();
        text_q.push_back(PCT_CHAR);
        text_q.push_back(8'h00);
        push_str("A%A");
        text_q.push_back(8'h00);
        send_text();
        push_str("%-1%\tb%zz%0x%+F");
        send_text();
        drain();
        write_limit(16'd2);
        push_str("ab%4");
        send_text();

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_limit(16'(limit_list[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            if (ph == 1) hold_req = 1'b1;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
            begin
                build_random_text();
                send_text();
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("[url_percent_decoder] OK");
        else
            $display("[url_percent_decoder] ERROR");
        $finish;
    end

endmodule
